// ===== design/pbd_pkg.sv =====
package pbd_pkg;

   localparam int RSP_DEPTH = 4;

   localparam logic [15:0] CAP_RESET = 16'd4062;

   localparam logic [4:0] BEGIN_LEN = 5'd11;
   localparam logic [4:0] END_LEN   = 5'd9;
   localparam logic [4:0] CERT_LEN  = 5'd11;
   localparam logic [4:0] RSA_LEN   = 5'd15;

   // configuration register indexes
   localparam logic CSR_TYPE_SELECT   = 1'b0;
   localparam logic CSR_BYTE_CAPACITY = 1'b1;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_HEADER  = 3'd1;
   localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
   localparam logic [2:0] ST_NO_NEWLINE = 3'd3;
   localparam logic [2:0] ST_BAD_CHAR   = 3'd4;
   localparam logic [2:0] ST_BAD_END    = 3'd5;

   typedef struct packed {
      logic        is_status;
      logic [7:0]  data_byte;
      logic [2:0]  status_code;
      logic [15:0] decoded_length;
      logic        last_result;
   } rsp_type;

   // results of one character, written into the response queue together
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [7:0] begin_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = "-";
         4'd5:    ch = "B";
         4'd6:    ch = "E";
         4'd7:    ch = "G";
         4'd8:    ch = "I";
         4'd9:    ch = "N";
         4'd10:   ch = " ";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] end_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = "-";
         4'd5:    ch = "E";
         4'd6:    ch = "N";
         4'd7:    ch = "D";
         4'd8:    ch = " ";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] label_char(input logic sel, input logic [3:0] idx);
      logic [7:0] ch;
      if (sel) begin
         case (idx)
            4'd0:    ch = "R";
            4'd1:    ch = "S";
            4'd2:    ch = "A";
            4'd3:    ch = " ";
            4'd4:    ch = "P";
            4'd5:    ch = "R";
            4'd6:    ch = "I";
            4'd7:    ch = "V";
            4'd8:    ch = "A";
            4'd9:    ch = "T";
            4'd10:   ch = "E";
            4'd11:   ch = " ";
            4'd12:   ch = "K";
            4'd13:   ch = "E";
            4'd14:   ch = "Y";
            default: ch = 8'h00;
         endcase
      end else begin
         case (idx)
            4'd0:    ch = "C";
            4'd1:    ch = "E";
            4'd2:    ch = "R";
            4'd3:    ch = "T";
            4'd4:    ch = "I";
            4'd5:    ch = "F";
            4'd6:    ch = "I";
            4'd7:    ch = "C";
            4'd8:    ch = "A";
            4'd9:    ch = "T";
            4'd10:   ch = "E";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

   // {valid, 6-bit value}
   function automatic logic [6:0] b64_decode(input logic [7:0] ch);
      logic [7:0] d;
      logic       ok;
      d  = 8'h00;
      ok = 1'b1;
      if (ch >= "A" && ch <= "Z") begin
         d = ch - 8'("A");
      end else if (ch >= "a" && ch <= "z") begin
         d = ch - 8'("a") + 8'd26;
      end else if (ch >= "0" && ch <= "9") begin
         d = ch - 8'("0") + 8'd52;
      end else if (ch == "+") begin
         d = 8'd62;
      end else if (ch == "/") begin
         d = 8'd63;
      end else begin
         ok = 1'b0;
      end
      return {ok, d[5:0]};
   endfunction

   function automatic logic is_white(input logic [7:0] ch);
      return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
   endfunction

endpackage

// ===== design/pbd_chan_if.sv =====
interface pbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_text;

   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface pbd_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_status;
   logic [7:0]  data_byte;
   logic [2:0]  status_code;
   logic [15:0] decoded_length;
   logic        last_result;

   modport source (output valid, output is_status, output data_byte, output status_code,
                   output decoded_length, output last_result, input ready);
   modport sink (input valid, input is_status, input data_byte, input status_code,
                 input decoded_length, input last_result, output ready);
endinterface

// ===== design/pem_base64_decoder_core.sv =====
// channel   dir  handshake       beat
// req_ch    in   valid/ready     text_char, end_of_text
// rsp_ch    out  valid/ready     is_status, data_byte, status_code, decoded_length, last_result
// csr       in   csr_we          csr_index, csr_wdata (no read-back)
//
// One character per cycle: a beat is registered, then decoded against the running
// state, and its results land in a small response queue. A character gives up to
// two results (byte then status); the queue drains one a cycle while rsp_ch is ready.
// req_ch stalls only while the queue lacks room for two more results.
// Synchronous reset clears the parser state and the queue; capacity resets to 4062.
module pem_base64_decoder_core #(
   parameter int RSP_DEPTH = pbd_pkg::RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   pbd_req_if.sink     req_ch,
   pbd_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic              sel_ff;
   logic [15:0]       cap_ff;
   logic              room;
   pbd_pkg::push_type push;
   pbd_pkg::rsp_type  head;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
         cap_ff <= pbd_pkg::CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pbd_pkg::CSR_TYPE_SELECT:   sel_ff <= csr_wdata[0];
            pbd_pkg::CSR_BYTE_CAPACITY: cap_ff <= csr_wdata;
            default:                    sel_ff <= sel_ff;
         endcase
      end
   end

   pbd_step u_step (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_char  (req_ch.text_char),
      .in_eot   (req_ch.end_of_text),
      .in_ready (req_ch.ready),
      .type_sel (sel_ff),
      .capacity (cap_ff),
      .room     (room),
      .push     (push)
   );

   pbd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_rsp   (head)
   );

   assign rsp_ch.is_status      = head.is_status;
   assign rsp_ch.data_byte      = head.data_byte;
   assign rsp_ch.status_code    = head.status_code;
   assign rsp_ch.decoded_length = head.decoded_length;
   assign rsp_ch.last_result    = head.last_result;

endmodule

// ===== design/pbd_step.sv =====
module pbd_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_char,
   input  logic               in_eot,
   output logic               in_ready,
   input  logic               type_sel,
   input  logic [15:0]        capacity,
   input  logic               room,
   output pbd_pkg::push_type  push
);

   localparam logic [2:0] PH_SEARCH  = 3'd0;
   localparam logic [2:0] PH_TYPE    = 3'd1;
   localparam logic [2:0] PH_NEWLINE = 3'd2;
   localparam logic [2:0] PH_BODY    = 3'd3;
   localparam logic [2:0] PH_ENDMARK = 3'd4;
   localparam logic [2:0] PH_ENDTYPE = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;

   logic        hold_ff, hold_in;
   logic [7:0]  char_ff;
   logic        eot_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  pend_ff, pend_in;
   logic [15:0] count_ff, count_in;

   logic        take, adv;
   logic        closed, emit;
   logic [2:0]  code;
   logic [7:0]  out_byte;
   logic [4:0]  lab_len, pos_inc;
   logic        lab_ok;
   logic [6:0]  b64;
   logic [3:0]  pend6;
   logic [15:0] count_inc;
   pbd_pkg::rsp_type data_rsp, stat_rsp;

   function automatic logic [2:0] end_code(input logic [2:0] ph);
      logic [2:0] c;
      unique case (ph)
         PH_SEARCH:  c = pbd_pkg::ST_NO_HEADER;
         PH_TYPE:    c = pbd_pkg::ST_WRONG_TYPE;
         PH_NEWLINE: c = pbd_pkg::ST_NO_NEWLINE;
         default:    c = pbd_pkg::ST_BAD_END;
      endcase
      return c;
   endfunction

   assign adv      = hold_ff && room;
   assign in_ready = !hold_ff || room;
   assign take     = in_valid && in_ready;
   assign hold_in  = take ? 1'b1 : (adv ? 1'b0 : hold_ff);

   assign lab_len   = type_sel ? pbd_pkg::RSA_LEN : pbd_pkg::CERT_LEN;
   assign lab_ok    = (pos_ff >= lab_len) || (char_ff == pbd_pkg::label_char(type_sel, pos_ff[3:0]));
   assign pos_inc   = (pos_ff < lab_len) ? pos_ff + 5'd1 : pos_ff;
   assign b64       = pbd_pkg::b64_decode(char_ff);
   assign pend6     = pend_ff + 4'd6;
   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      closed   = 1'b0;
      emit     = 1'b0;
      code     = pbd_pkg::ST_OK;
      out_byte = 8'h00;

      if (phase_ff == PH_DONE) begin
         // swallow the rest of the text
         if (eot_ff) begin
            phase_in = PH_SEARCH;
            pos_in   = 5'd0;
            acc_in   = 12'd0;
            pend_in  = 4'd0;
            count_in = 16'd0;
         end
      end else begin
         if (char_ff == 8'h00) begin
            code   = end_code(phase_ff);
            closed = 1'b1;
         end else begin
            case (phase_ff)
               PH_SEARCH: begin
                  if (pos_ff < pbd_pkg::BEGIN_LEN &&
                      char_ff == pbd_pkg::begin_char(pos_ff[3:0])) begin
                     if (pos_ff + 5'd1 == pbd_pkg::BEGIN_LEN) begin
                        phase_in = PH_TYPE;
                        pos_in   = 5'd0;
                     end else begin
                        pos_in = pos_ff + 5'd1;
                     end
                  end else if (char_ff == "-") begin
                     // a dash run longer than five keeps the match at five
                     pos_in = (pos_ff == 5'd5) ? 5'd5 : 5'd1;
                  end else begin
                     pos_in = 5'd0;
                  end
               end
               PH_TYPE, PH_ENDTYPE: begin
                  if (!lab_ok) begin
                     closed = 1'b1;
                     code   = (phase_ff == PH_TYPE) ? pbd_pkg::ST_WRONG_TYPE : pbd_pkg::ST_BAD_END;
                  end else begin
                     pos_in = pos_inc;
                     if (pos_inc >= lab_len) begin
                        if (phase_ff == PH_TYPE) begin
                           phase_in = PH_NEWLINE;
                           pos_in   = 5'd0;
                        end else begin
                           closed = 1'b1;
                           code   = (pend_ff != 4'd0 || count_ff >= capacity) ?
                                    pbd_pkg::ST_BAD_END : pbd_pkg::ST_OK;
                        end
                     end
                  end
               end
               PH_NEWLINE: begin
                  if (char_ff == 8'h0A) begin
                     phase_in = PH_BODY;
                     if (count_ff >= capacity) begin
                        closed = 1'b1;
                        code   = pbd_pkg::ST_BAD_END;
                     end
                  end
               end
               PH_BODY: begin
                  if (count_ff >= capacity) begin
                     closed = 1'b1;
                     code   = pbd_pkg::ST_BAD_END;
                  end else if (b64[6]) begin
                     acc_in = {acc_ff[5:0], b64[5:0]};
                     if (pend6 >= 4'd8) begin
                        pend_in  = pend6 - 4'd8;
                        emit     = 1'b1;
                        out_byte = 8'({acc_ff[5:0], b64[5:0]} >> pend_in);
                        count_in = count_inc;
                        if (count_inc >= capacity) begin
                           closed = 1'b1;
                           code   = pbd_pkg::ST_BAD_END;
                        end
                     end else begin
                        pend_in = pend6;
                     end
                  end else if (pbd_pkg::is_white(char_ff)) begin
                     pend_in = pend_ff;
                  end else if (char_ff == "=") begin
                     pend_in = 4'd0;
                  end else if (char_ff == "-") begin
                     phase_in = PH_ENDMARK;
                     pos_in   = 5'd1;
                  end else begin
                     closed = 1'b1;
                     code   = pbd_pkg::ST_BAD_CHAR;
                  end
               end
               PH_ENDMARK: begin
                  if (pos_ff < pbd_pkg::END_LEN &&
                      char_ff == pbd_pkg::end_char(pos_ff[3:0])) begin
                     if (pos_ff + 5'd1 == pbd_pkg::END_LEN) begin
                        phase_in = PH_ENDTYPE;
                        pos_in   = 5'd0;
                     end else begin
                        pos_in = pos_ff + 5'd1;
                     end
                  end else begin
                     closed = 1'b1;
                     code   = pbd_pkg::ST_BAD_END;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end

         if (!closed && eot_ff) begin
            code   = end_code(phase_in);
            closed = 1'b1;
         end

         if (closed) begin
            if (eot_ff) begin
               phase_in = PH_SEARCH;
               pos_in   = 5'd0;
               acc_in   = 12'd0;
               pend_in  = 4'd0;
               count_in = 16'd0;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   always_comb begin
      data_rsp                = '0;
      data_rsp.data_byte      = out_byte;
      data_rsp.last_result    = !closed;
      stat_rsp                = '0;
      stat_rsp.is_status      = 1'b1;
      stat_rsp.status_code    = code;
      stat_rsp.decoded_length = emit ? count_inc : count_ff;
      stat_rsp.last_result    = 1'b1;

      push        = '0;
      push.first  = emit ? data_rsp : stat_rsp;
      push.second = stat_rsp;
      if (adv) begin
         push.count = 2'(emit) + 2'(closed);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff <= in_char;
         eot_ff  <= in_eot;
      end
      if (reset) begin
         hold_ff  <= 1'b0;
         phase_ff <= PH_SEARCH;
         pos_ff   <= 5'd0;
         acc_ff   <= 12'd0;
         pend_ff  <= 4'd0;
         count_ff <= 16'd0;
      end else begin
         hold_ff <= hold_in;
         if (adv) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            acc_ff   <= acc_in;
            pend_ff  <= pend_in;
            count_ff <= count_in;
         end
      end
   end

`ifndef SYNTH
   a_two_is_byte_then_status: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.is_status && push.second.is_status)
      else $error("two results must be a byte followed by status");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd1 |-> push.first.last_result)
      else $error("single result must carry last flag");

   a_done_no_output: assert property (@(posedge clock) disable iff (reset)
      adv && phase_ff == PH_DONE |-> push.count == 2'd0)
      else $error("result produced after status");

   a_count_below_cap: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && !push.first.is_status |=> count_ff <= capacity || phase_ff == PH_DONE
      || phase_ff == PH_SEARCH)
      else $error("byte count passed capacity while open");
`endif

endmodule

// ===== design/pbd_rsp_fifo.sv =====
module pbd_rsp_fifo #(
   parameter int DEPTH = pbd_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  pbd_pkg::push_type push,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output pbd_pkg::rsp_type  out_rsp
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

   pbd_pkg::rsp_type entry_ff [DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   assign room      = count_ff <= ROOM_MAX;
   assign out_valid = count_ff != '0;
   assign out_rsp   = entry_ff[rptr_ff];
   assign pop       = out_valid && out_ready;

   assign wptr_in  = wptr_ff + PW'(push.count);
   assign rptr_in  = rptr_ff + PW'(pop);
   assign count_in = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wptr_ff + PW'(1)] <= push.second;
      end
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("response queue overfilled");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> $past(count_ff) <= CW'(DEPTH) && room)
      else $error("push without room");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff != CW'(DEPTH) |-> PW'(wptr_ff - rptr_ff) == PW'(count_ff))
      else $error("pointers disagree with count");
`endif

endmodule
